// ----- rtl/spk_pkg.sv -----
// Shared types, constants and round functions for the Speck 64/128 cipher.
// No dependencies; imported by the engine and the test files, not by spk_ram.
package spk_pkg;

	localparam int ROUNDS    = 27;
	localparam int KEY_WORDS = 4;
	localparam int WORD_W    = 32;
	localparam int RK_AW     = $clog2(ROUNDS);

	localparam int ROT_ALPHA = 8;
	localparam int ROT_BETA  = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [RK_AW-1:0]  rk_addr_t;

	localparam rk_addr_t LAST_RK = rk_addr_t'(ROUNDS - 1);

	// Configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t KEY_IDX_0 = 2'd0;
	localparam cfg_idx_t KEY_IDX_1 = 2'd1;
	localparam cfg_idx_t KEY_IDX_2 = 2'd2;
	localparam cfg_idx_t KEY_IDX_3 = 2'd3;

	// Request codes
	localparam logic REQ_ENC = 1'b0;
	localparam logic REQ_DEC = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_CIPHER
	} state_t;

	typedef struct packed {
		word_t x;
		word_t y;
	} blk_t;

	function automatic word_t rotr(input word_t v, input int unsigned r);
		return (v >> r) | (v << (WORD_W - r));
	endfunction

	function automatic word_t rotl(input word_t v, input int unsigned r);
		return (v << r) | (v >> (WORD_W - r));
	endfunction

	function automatic blk_t enc_round(input blk_t b, input word_t k);
		blk_t o;
		o.x = (rotr(b.x, ROT_ALPHA) + b.y) ^ k;
		o.y = rotl(b.y, ROT_BETA) ^ o.x;
		return o;
	endfunction

	function automatic blk_t dec_round(input blk_t b, input word_t k);
		blk_t o;
		o.y = rotr(b.y ^ b.x, ROT_BETA);
		o.x = rotl((b.x ^ k) - o.y, ROT_ALPHA);
		return o;
	endfunction

endpackage

// ----- rtl/spk_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module spk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 27
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/speck_64_128_block_cipher.sv -----
// Speck 64/128 engine: one round per cycle, round keys read from spk_ram.
// Encrypt or decrypt: start accepted while idle, result strobed on done as the
// engine returns to idle (busy low), so the next start is taken in that same cycle.
// A key write runs the key schedule in the EXPAND state (busy, cfg_ready low).
// Reset clears the key words and runs the same schedule for the zero key.
// Results are strobed for one cycle; the receiver cannot stall. Uses spk_pkg.
module speck_64_128_block_cipher
	import spk_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,

	input  logic     start,
	output logic     busy,
	input  logic     req_type,
	input  word_t    in_word_lo,
	input  word_t    in_word_hi,

	output logic     done,
	output word_t    out_word_lo,
	output word_t    out_word_hi,

	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  cfg_idx_t cfg_index,
	input  word_t    cfg_data
);

	state_t   state_q, state_d;
	rk_addr_t cnt_q;
	word_t    key_q   [KEY_WORDS];
	word_t    kw_new  [KEY_WORDS];
	word_t    right_q;
	word_t    left_q  [KEY_WORDS-1];
	word_t    lw_new;
	logic     dec_q;
	blk_t     blk_q, blk_nxt;
	logic     done_q;
	word_t    out_lo_q, out_hi_q;

	logic     cfg_fire, start_fire, last;
	logic     rk_we;
	rk_addr_t rk_raddr;
	word_t    rk_rdata;

	spk_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ROUNDS)
	) u_rk_ram (
		.clk  (clk),
		.we   (rk_we),
		.waddr(cnt_q),
		.wdata(right_q),
		.raddr(rk_raddr),
		.rdata(rk_rdata)
	);

	assign busy       = (state_q != ST_IDLE);
	// hold the key write off while a block is offered
	assign cfg_ready  = (state_q == ST_IDLE) && !start;
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign start_fire = start && !busy;
	assign last       = (cnt_q == LAST_RK);
	assign rk_we      = (state_q == ST_EXPAND);

	// Merge the written word into the key set
	always_comb begin
		for (int i = 0; i < KEY_WORDS; i++) begin
			kw_new[i] = key_q[i];
		end
		unique case (cfg_index)
			KEY_IDX_0: kw_new[0] = cfg_data;
			KEY_IDX_1: kw_new[1] = cfg_data;
			KEY_IDX_2: kw_new[2] = cfg_data;
			KEY_IDX_3: kw_new[3] = cfg_data;
			default:   kw_new[0] = key_q[0];
		endcase
	end

	// One schedule step; the round index is the constant
	assign lw_new  = (rotr(left_q[0], ROT_ALPHA) + right_q) ^ word_t'(cnt_q);
	assign blk_nxt = (dec_q == REQ_DEC) ? dec_round(blk_q, rk_rdata)
	                                    : enc_round(blk_q, rk_rdata);

	always_comb begin
		state_d  = state_q;
		rk_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				// prefetch the first round key while waiting
				rk_raddr = (req_type == REQ_DEC) ? LAST_RK : '0;
				if (cfg_fire) begin
					state_d = ST_EXPAND;
				end else if (start_fire) begin
					state_d = ST_CIPHER;
				end
			end
			ST_EXPAND: begin
				if (last) begin
					state_d = ST_IDLE;
				end
			end
			ST_CIPHER: begin
				if (!last) begin
					rk_raddr = (dec_q == REQ_DEC) ? rk_addr_t'(LAST_RK - cnt_q - 1'b1)
					                              : rk_addr_t'(cnt_q + 1'b1);
				end
				if (last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EXPAND;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			right_q <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
			for (int i = 0; i < KEY_WORDS-1; i++) begin
				left_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cfg_fire) begin
						for (int i = 0; i < KEY_WORDS; i++) begin
							key_q[i] <= kw_new[i];
						end
						right_q <= kw_new[0];
						for (int i = 0; i < KEY_WORDS-1; i++) begin
							left_q[i] <= kw_new[i+1];
						end
					end
				end
				ST_EXPAND: begin
					cnt_q   <= last ? '0 : rk_addr_t'(cnt_q + 1'b1);
					right_q <= rotl(right_q, ROT_BETA) ^ lw_new;
					// rotate the left words so the next one to use sits at the head
					for (int i = 0; i < KEY_WORDS-2; i++) begin
						left_q[i] <= left_q[i+1];
					end
					left_q[KEY_WORDS-2] <= lw_new;
				end
				ST_CIPHER: begin
					cnt_q <= last ? '0 : rk_addr_t'(cnt_q + 1'b1);
					if (last) begin
						done_q <= 1'b1;
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_fire && !cfg_fire) begin
			dec_q   <= req_type;
			blk_q.x <= in_word_hi;
			blk_q.y <= in_word_lo;
		end else if (state_q == ST_CIPHER) begin
			blk_q <= blk_nxt;
		end
		if (state_q == ST_CIPHER && last) begin
			out_lo_q <= blk_nxt.y;
			out_hi_q <= blk_nxt.x;
		end
	end

	assign done        = done_q;
	assign out_word_lo = out_lo_q;
	assign out_word_hi = out_hi_q;

endmodule

// ----- test/speck_64_128_block_cipher_chk.sv -----
// Checker for the Speck 64/128 engine: mirrors the key registers, rebuilds the
// round keys, predicts each block and compares every done beat with the oldest one.
// Depends on spk_pkg for the port types; watches the block's ports only.
module speck_64_128_block_cipher_chk
	import spk_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  logic     req_type,
	input  word_t    in_word_lo,
	input  word_t    in_word_hi,
	input  logic     done,
	input  word_t    out_word_lo,
	input  word_t    out_word_hi,
	input  logic     cfg_valid,
	input  logic     cfg_ready,
	input  cfg_idx_t cfg_index,
	input  word_t    cfg_data,
	output int       pending,
	output int       checked,
	output int       errors
);
	timeunit 1ns;
	timeprecision 1ps;

	word_t key_word[KEY_WORDS];
	word_t sched_key[ROUNDS];
	blk_t  block_q[$];

	function automatic word_t ror8(input word_t v);
		return {v[7:0], v[31:8]};
	endfunction

	function automatic word_t rol8(input word_t v);
		return {v[23:0], v[31:24]};
	endfunction

	function automatic word_t ror3(input word_t v);
		return {v[2:0], v[31:3]};
	endfunction

	function automatic word_t rol3(input word_t v);
		return {v[28:0], v[31:29]};
	endfunction

	// Left words are consumed in turn; the round index is the constant.
	function automatic void rebuild_schedule();
		word_t lft[KEY_WORDS-1];
		word_t rgt;
		int    slot;
		for (int i = 0; i < KEY_WORDS - 1; i++)
			lft[i] = key_word[i+1];
		rgt = key_word[0];
		sched_key[0] = rgt;
		for (int n = 0; n < ROUNDS - 1; n++) begin
			slot = n % (KEY_WORDS - 1);
			lft[slot] = (ror8(lft[slot]) + rgt) ^ word_t'(n);
			rgt = rol3(rgt) ^ lft[slot];
			sched_key[n+1] = rgt;
		end
	endfunction

	function automatic blk_t speck_block(input logic op, input word_t lo, input word_t hi);
		blk_t b;
		b.x = hi;
		b.y = lo;
		if (op == REQ_ENC) begin
			for (int r = 0; r < ROUNDS; r++) begin
				b.x = (ror8(b.x) + b.y) ^ sched_key[r];
				b.y = rol3(b.y) ^ b.x;
			end
		end else begin
			for (int r = 0; r < ROUNDS; r++) begin
				b.y = ror3(b.y ^ b.x);
				b.x = rol8((b.x ^ sched_key[ROUNDS-1-r]) - b.y);
			end
		end
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		blk_t want;
		if (!arst_n) begin
			foreach (key_word[i])
				key_word[i] = '0;
			rebuild_schedule();
			block_q.delete();
			pending = 0;
			checked = 0;
			errors  = 0;
		end else begin
			// retire the oldest block before taking a new one in the same edge
			if (done) begin
				if (block_q.size() == 0) begin
					$error("done beat with no block outstanding: lo %h hi %h",
						out_word_lo, out_word_hi);
					errors++;
				end else begin
					want = block_q.pop_front();
					if (out_word_lo !== want.y) begin
						$error("out_word_lo: expected %h, got %h", want.y, out_word_lo);
						errors++;
					end
					if (out_word_hi !== want.x) begin
						$error("out_word_hi: expected %h, got %h", want.x, out_word_hi);
						errors++;
					end
					checked++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				key_word[cfg_index] = cfg_data;
				rebuild_schedule();
			end
			if (start && !busy)
				block_q.push_back(speck_block(req_type, in_word_lo, in_word_hi));
			pending = block_q.size();
		end
	end

endmodule

// ----- test/speck_64_128_block_cipher_tb.sv -----
// Top of the Speck 64/128 testbench: clock, reset, key writes and block stimulus.
// Instantiates speck_64_128_block_cipher and speck_64_128_block_cipher_chk;
// the checker does all prediction and comparison. Uses spk_pkg.
module speck_64_128_block_cipher_tb
	import spk_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int       N_PHASES   = 8;
	localparam int       PHASE_BLKS = 229;
	localparam cfg_idx_t KEY_SLOT[KEY_WORDS] = '{KEY_IDX_0, KEY_IDX_1, KEY_IDX_2, KEY_IDX_3};

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     req_type;
	word_t    in_word_lo;
	word_t    in_word_hi;
	logic     done;
	word_t    out_word_lo;
	word_t    out_word_hi;
	logic     cfg_valid;
	logic     cfg_ready;
	cfg_idx_t cfg_index;
	word_t    cfg_data;

	int pending;
	int checked;
	int errors;
	int idle_pct;
	int n_enc;
	int n_dec;
	int n_keys;

	speck_64_128_block_cipher i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.in_word_lo  (in_word_lo),
		.in_word_hi  (in_word_hi),
		.done        (done),
		.out_word_lo (out_word_lo),
		.out_word_hi (out_word_hi),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	speck_64_128_block_cipher_chk i_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.in_word_lo  (in_word_lo),
		.in_word_hi  (in_word_hi),
		.done        (done),
		.out_word_lo (out_word_lo),
		.out_word_hi (out_word_hi),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pending     (pending),
		.checked     (checked),
		.errors      (errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("speck_64_128_block_cipher_tb NOT OK");
		$finish;
	end

	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Caller is at a falling edge; returns at a falling edge with start low.
	task automatic send_block(input logic op, input word_t lo, input word_t hi);
		start      = 1'b1;
		req_type   = op;
		in_word_lo = lo;
		in_word_hi = hi;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		start = 1'b0;
		if (op == REQ_DEC)
			n_dec++;
		else
			n_enc++;
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
			repeat ($urandom_range(1, 7)) @(negedge clk);
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_key(input cfg_idx_t idx, input word_t data);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		n_keys++;
	endtask

	task automatic load_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
		write_key(KEY_IDX_0, k0);
		write_key(KEY_IDX_1, k1);
		write_key(KEY_IDX_2, k2);
		write_key(KEY_IDX_3, k3);
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = REQ_ENC;
		in_word_lo = '0;
		in_word_hi = '0;
		cfg_valid  = 1'b0;
		cfg_index  = KEY_IDX_0;
		cfg_data   = '0;
		idle_pct   = 0;
		n_enc      = 0;
		n_dec      = 0;
		n_keys     = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// key left at reset: all-zero schedule
		send_block(REQ_ENC, '0, '0);
		send_block(REQ_DEC, '0, '0);
		send_block(REQ_ENC, '1, '1);
		send_block(REQ_DEC, '1, '1);

		// published 64/128 vector, then its inverse
		load_key(32'h03020100, 32'h0b0a0908, 32'h13121110, 32'h1b1a1918);
		send_block(REQ_ENC, 32'h7475432d, 32'h3b726574);
		send_block(REQ_DEC, 32'h454e028b, 32'h8c6fa548);
		idle_pct = 50;
		send_block(REQ_ENC, 32'h55555555, 32'haaaaaaaa);
		send_block(REQ_DEC, 32'haaaaaaaa, 32'h55555555);
		send_block(REQ_ENC, 32'h00000001, 32'h80000000);
		send_block(REQ_DEC, 32'h80000000, 32'h00000001);

		load_key('1, '1, '1, '1);
		send_block(REQ_ENC, '0, '1);
		send_block(REQ_DEC, '1, '0);
		send_block(REQ_ENC, 32'haaaaaaaa, 32'h55555555);
		send_block(REQ_DEC, 32'h55555555, 32'haaaaaaaa);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph == 0)
				load_key('0, '0, '0, '0);
			else if (ph == 1)
				load_key('1, '1, '1, '1);
			else begin
				for (int k = 0; k < KEY_WORDS; k++)
					if (k == ph % KEY_WORDS || $urandom_range(0, 1) == 1)
						write_key(KEY_SLOT[k], pick_word());
			end
			case ($urandom_range(0, 2))
				0:       idle_pct = 0;
				1:       idle_pct = 30;
				default: idle_pct = 60;
			endcase
			// no idling at all in the closing phase
			if (ph == N_PHASES - 1)
				idle_pct = 0;
			for (int i = 0; i < PHASE_BLKS; i++) begin
				send_block(logic'($urandom_range(0, 1)), pick_word(), pick_word());
				if (ph != N_PHASES - 1 && $urandom_range(0, 149) == 0)
					drain();
			end
		end

		drain();
		repeat (60) @(posedge clk);
		$display("Run covered %0d encrypt and %0d decrypt blocks (%0d results checked)",
			n_enc, n_dec, checked);
		$display("across %0d key register writes, zero, all-ones and random keys.", n_keys);
		if (errors == 0)
			$display("speck_64_128_block_cipher_tb OK");
		else
			$display("speck_64_128_block_cipher_tb NOT OK");
		$finish;
	end

endmodule
